FILE: rtl/cfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue package
// Operation codes, fixed field widths and the control group handed to the
// cell chain.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int FUNC_W = 2;
  localparam int CAP_W  = 11;
  localparam int PORT_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QRY = 2'd2;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic enq;
    logic deq;
  } ctrl_t;

endpackage

FILE: rtl/cfc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue storage cell
// One queue slot: load the pushed item when it is the insertion point,
// take the neighbour's item on a dequeue, otherwise hold.
// ----------------------------------------------------------------------------
module cfc_cell #(
  parameter int WIDTH = 32,
  parameter int CNT_W = 11,
  parameter int INDEX = 0
) (
  input  logic              clk_i,
  input  cfc_pkg::ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [WIDTH-1:0]  push_i,
  input  logic [WIDTH-1:0]  nbr_i,
  output logic [WIDTH-1:0]  data_o
);

  logic [WIDTH-1:0] data_d, data_q;
  logic             sel;

  assign sel = (count_i == CNT_W'(INDEX));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.enq && sel) begin
      data_d = push_i;
    end else if (ctrl_i.deq) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/cfc_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue cell chain
// A row of storage cells with the oldest item in cell zero; a dequeue moves
// every item one cell towards the head.
// ----------------------------------------------------------------------------
module cfc_chain #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int CNT_W = 11
) (
  input  logic              clk_i,
  input  cfc_pkg::ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [WIDTH-1:0]  push_i,
  output logic [WIDTH-1:0]  head_o
);

  // One extra tap past the last cell feeds it a blank on a dequeue
  logic [WIDTH-1:0] tap [DEPTH+1];

  assign tap[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cfc_cell #(
      .WIDTH (WIDTH),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .push_i  (push_i),
      .nbr_i   (tap[i+1]),
      .data_o  (tap[i])
    );
  end

  assign head_o = tap[0];

endmodule

FILE: rtl/circular_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue
// Bounded FIFO of signed values with a programmable capacity, built as a
// shifting chain of storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per handshake:
//   an operation code (enqueue, dequeue, query; the spare code acts as a
//   query) and a value used only by an enqueue.
//   Output channel (out_valid_o / out_stall_i) returns one result item per
//   input item: success bit, oldest and newest values (-1 when empty),
//   empty and full flags, all taken after the operation.
//   Capacity register (cap_we_i / cap_wdata_i): write only while idle; the
//   value is clamped to 1..DEPTH and the write empties the queue.
// Timing:
//   The result is valid in the cycle after the input handshake. One item
//   is taken every cycle while no stalled result holds the input; every cell of
//   the chain updates in the same cycle for an enqueue or the shift of a dequeue.
//   The result fields are read straight from the queue state, so while a
//   result is stalled the input stalls too and the state holds.
// Reset:
//   Queue empty, capacity min(1024, DEPTH), no result pending. Cell
//   contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // capacity register
  input  logic                              cap_we_i,
  input  logic [cfc_pkg::CAP_W-1:0]         cap_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cfc_pkg::FUNC_W-1:0]        in_func_i,
  input  logic signed [cfc_pkg::PORT_W-1:0] in_push_value_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_accepted_o,
  output logic signed [cfc_pkg::PORT_W-1:0] out_oldest_value_o,
  output logic signed [cfc_pkg::PORT_W-1:0] out_newest_value_o,
  output logic                              out_empty_flag_o,
  output logic                              out_full_flag_o
);

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RST_CAP = (1024 > DEPTH) ? DEPTH : 1024;

  // Sign-extend a stored item from the storage width, keep the port bits
  function automatic logic [cfc_pkg::PORT_W-1:0] to_port(input logic [DATA_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(signed'(v));
    return w[cfc_pkg::PORT_W-1:0];
  endfunction

  logic [CNT_W-1:0]      count_d, count_q;
  logic [CNT_W-1:0]      cap_d, cap_q;
  logic [DATA_WIDTH-1:0] newest_d, newest_q;
  logic                  out_valid_d, out_valid_q;
  logic                  acc_d, acc_q;

  logic                  in_take;
  logic                  is_empty, is_full;
  logic                  ok;
  logic [63:0]           push_wide;
  logic [DATA_WIDTH-1:0] push_store;
  logic [DATA_WIDTH-1:0] head;
  cfc_pkg::ctrl_t        ctrl;

  // Take a new item only when no stalled result is pending
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == cap_q);

  // Zero-extend the port value, then keep the storage bits
  assign push_wide  = {32'd0, in_push_value_i};
  assign push_store = push_wide[DATA_WIDTH-1:0];

  // Decode the operation; the spare code behaves as a query
  always_comb begin
    ok = 1'b1;
    unique case (in_func_i)
      cfc_pkg::FUNC_ENQ: ok = !is_full;
      cfc_pkg::FUNC_DEQ: ok = !is_empty;
      cfc_pkg::FUNC_QRY: ok = 1'b1;
      default:           ok = 1'b1;
    endcase
  end

  assign ctrl.enq = in_take && (in_func_i == cfc_pkg::FUNC_ENQ) && !is_full;
  assign ctrl.deq = in_take && (in_func_i == cfc_pkg::FUNC_DEQ) && !is_empty;

  // Occupancy: a capacity write drops every item
  always_comb begin
    count_d = count_q;
    if (cap_we_i) begin
      count_d = '0;
    end else if (ctrl.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Clamp the capacity to the physical depth, zero reads as one
  always_comb begin
    cap_d = cap_q;
    if (cap_we_i) begin
      if (cap_wdata_i == '0) begin
        cap_d = CNT_W'(1);
      end else if (32'(cap_wdata_i) > DEPTH) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = CNT_W'(cap_wdata_i);
      end
    end
  end

  // The newest item is the last one pushed while any item remains
  assign newest_d = ctrl.enq ? push_store : newest_q;

  always_comb begin
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    if (in_take) begin
      out_valid_d = 1'b1;
      acc_d       = ok;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CNT_W'(RST_CAP);
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    newest_q <= newest_d;
    acc_q    <= acc_d;
  end

  cfc_chain #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .count_i (count_q),
    .push_i  (push_store),
    .head_o  (head)
  );

  // Result fields come from the state left by the last accepted item
  assign out_valid_o        = out_valid_q;
  assign out_accepted_o     = acc_q;
  assign out_oldest_value_o = is_empty ? '1 : to_port(head);
  assign out_newest_value_o = is_empty ? '1 : to_port(newest_q);
  assign out_empty_flag_o   = is_empty;
  assign out_full_flag_o    = is_full;

  // Occupancy never passes the programmed capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("occupancy above capacity");

  // A refused enqueue leaves the occupancy alone
  a_enq_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && (in_func_i == cfc_pkg::FUNC_ENQ) && is_full && !cap_we_i)
    |=> (count_q == $past(count_q)))
    else $error("refused enqueue changed occupancy");

  // An accepted dequeue drops exactly one item
  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.deq && !cap_we_i) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("dequeue did not drop one item");

  // Every accepted item yields a pending result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> out_valid_o)
    else $error("accepted item produced no result");

  // A capacity write empties the queue
  a_cap_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_we_i |=> out_empty_flag_o)
    else $error("capacity write did not empty the queue");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO queue testbench
// Drives enqueue, dequeue and query items through the valid/stall channels
// under random gaps and stalls, mirrors the ring in a local predictor and
// compares every returned status item, field by field, with the one
// predicted for the oldest outstanding input item.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD  = 10;
  localparam int RING_DEPTH  = 1024;
  localparam int CYCLE_LIMIT = 300000;
  localparam int GAP_MAX     = 14;
  // Spare operation code: the block treats it as a query
  localparam logic [cfc_pkg::FUNC_W-1:0] FUNC_SPARE  = 2'd3;
  localparam logic [cfc_pkg::PORT_W-1:0] VACANT_READ = '1;
  // Phase capacity that stands for a freshly drawn random value
  localparam int CAP_RANDOM = -1;

  typedef struct packed {
    logic                       accepted;
    logic [cfc_pkg::PORT_W-1:0] oldest;
    logic [cfc_pkg::PORT_W-1:0] newest;
    logic                       empty;
    logic                       full;
  } status_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [cfc_pkg::FUNC_W-1:0] func;
    logic [cfc_pkg::PORT_W-1:0] value;   // push value, or capacity on a register row
    logic                       typed;   // status below is the expected one
    status_t                    status;
  } plan_row_t;

  localparam status_t ST_EMPTY_OK = '{1'b1, VACANT_READ, VACANT_READ, 1'b1, 1'b0};
  localparam status_t ST_EMPTY_NO = '{1'b0, VACANT_READ, VACANT_READ, 1'b1, 1'b0};
  localparam status_t ST_NONE     = '0;

  // Directed opening: empty queue, extreme values, every operation, refused
  // operations, wrap-round, and the capacity extremes (0 and 2047 clamp).
  localparam plan_row_t PLAN [30] = '{
    '{ROW_ITEM, cfc_pkg::FUNC_QRY, 32'h0000_0000, 1'b1, ST_EMPTY_OK},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY_NO},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h7FFF_FFFF, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h8000_0000, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0}},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 1'b0, ST_NONE},
    '{ROW_ITEM, FUNC_SPARE,        32'h0000_3039, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY_OK},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY_NO},
    '{ROW_CAP,  cfc_pkg::FUNC_QRY, 32'd2,         1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h5A5A_5A5A, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'hA5A5_A5A5, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0001, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0002, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_QRY, 32'hDEAD_BEEF, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b0, ST_NONE},
    '{ROW_CAP,  cfc_pkg::FUNC_QRY, 32'd1,         1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0003, 1'b1,
      '{1'b1, 32'h0000_0003, 32'h0000_0003, 1'b0, 1'b1}},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0004, 1'b1,
      '{1'b0, 32'h0000_0003, 32'h0000_0003, 1'b0, 1'b1}},
    '{ROW_ITEM, cfc_pkg::FUNC_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY_OK},
    '{ROW_CAP,  cfc_pkg::FUNC_QRY, 32'd0,         1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0007, 1'b1,
      '{1'b1, 32'h0000_0007, 32'h0000_0007, 1'b0, 1'b1}},
    '{ROW_CAP,  cfc_pkg::FUNC_QRY, 32'd2047,      1'b0, ST_NONE},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_0009, 1'b1,
      '{1'b1, 32'h0000_0009, 32'h0000_0009, 1'b0, 1'b0}},
    '{ROW_ITEM, cfc_pkg::FUNC_ENQ, 32'h0000_000A, 1'b0, ST_NONE}
  };

  // Random phases: capacity, item count and enqueue share in percent.
  // The capacity-200 phase is enqueue-heavy so that the queue fills up.
  localparam int PHASE_CAPS [12] = '{1, 2, 3, 0, 5, 8, 2047, 1024, 17, 200,
                                     CAP_RANDOM, CAP_RANDOM};
  localparam int PHASE_ITEMS [12] = '{50, 50, 50, 50, 50, 50, 50, 50, 50, 330,
                                      50, 50};
  localparam int PHASE_ENQ_PCT [12] = '{50, 70, 25, 50, 85, 60, 50, 70, 45, 90,
                                        65, 35};

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cap_we_i = 1'b0;
  logic [cfc_pkg::CAP_W-1:0]         cap_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [cfc_pkg::FUNC_W-1:0]        in_func_i = cfc_pkg::FUNC_QRY;
  logic signed [cfc_pkg::PORT_W-1:0] in_push_value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              out_accepted_o;
  logic signed [cfc_pkg::PORT_W-1:0] out_oldest_value_o;
  logic signed [cfc_pkg::PORT_W-1:0] out_newest_value_o;
  logic                              out_empty_flag_o;
  logic                              out_full_flag_o;

  // Predictor state: a mirror of the ring and its indices
  logic [cfc_pkg::PORT_W-1:0] ring_mirror [RING_DEPTH];
  int                         slots_used = RING_DEPTH;
  int                         head_slot = 0;
  int                         tail_slot = 0;
  bit                         ring_vacant = 1'b1;

  status_t pending_status [$];
  int      errors = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  bit      calm_phase = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  circular_fifo_queue dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cap_we_i           (cap_we_i),
    .cap_wdata_i        (cap_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_func_i          (in_func_i),
    .in_push_value_i    (in_push_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_accepted_o     (out_accepted_o),
    .out_oldest_value_o (out_oldest_value_o),
    .out_newest_value_o (out_newest_value_o),
    .out_empty_flag_o   (out_empty_flag_o),
    .out_full_flag_o    (out_full_flag_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Advance an index round the slots in use
  function automatic int step_slot(input int idx);
    return (idx + 1 >= slots_used) ? 0 : idx + 1;
  endfunction

  function automatic bit ring_full();
    return !ring_vacant && step_slot(tail_slot) == head_slot;
  endfunction

  // Apply one operation to the mirror and return the status it reports
  function automatic status_t predict_status(input logic [cfc_pkg::FUNC_W-1:0] func,
                                             input logic [cfc_pkg::PORT_W-1:0] value);
    status_t st;
    st.accepted = 1'b1;
    if (func == cfc_pkg::FUNC_ENQ) begin
      if (ring_full()) begin
        st.accepted = 1'b0;
      end else begin
        // Restart from slot 0 when the queue was empty
        if (ring_vacant) begin
          head_slot   = 0;
          tail_slot   = 0;
          ring_vacant = 1'b0;
        end else begin
          tail_slot = step_slot(tail_slot);
        end
        ring_mirror[tail_slot] = value;
      end
    end else if (func == cfc_pkg::FUNC_DEQ) begin
      if (ring_vacant) begin
        st.accepted = 1'b0;
      end else if (head_slot == tail_slot) begin
        // Last element gone: empty the queue and rewind both indices
        head_slot   = 0;
        tail_slot   = 0;
        ring_vacant = 1'b1;
      end else begin
        head_slot = step_slot(head_slot);
      end
    end
    st.oldest = ring_vacant ? VACANT_READ : ring_mirror[head_slot];
    st.newest = ring_vacant ? VACANT_READ : ring_mirror[tail_slot];
    st.empty  = ring_vacant;
    st.full   = ring_full();
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int draw_gap();
    return calm_phase ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [cfc_pkg::FUNC_W-1:0] draw_func(input int enq_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) return cfc_pkg::FUNC_ENQ;
    if (roll < 94)      return cfc_pkg::FUNC_DEQ;
    if (roll < 98)      return cfc_pkg::FUNC_QRY;
    return FUNC_SPARE;
  endfunction

  // Mostly full-range values, with the extremes now and then
  function automatic logic [cfc_pkg::PORT_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Widen a one-bit flag to a compare word
  function automatic logic [cfc_pkg::PORT_W-1:0] flag_word(input logic b);
    logic [cfc_pkg::PORT_W-1:0] w;
    w    = '0;
    w[0] = b;
    return w;
  endfunction

  // Offer one item after a random gap, hold it until taken, then predict.
  // Valid stays high on return; the next call or a drain lowers it.
  task automatic send_item(input logic [cfc_pkg::FUNC_W-1:0] func,
                           input logic [cfc_pkg::PORT_W-1:0] value,
                           input logic typed, input status_t typed_status);
    status_t st;
    repeat (draw_gap()) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    in_func_i       <= func;
    in_push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    st = predict_status(func, value);
    pending_status.push_back(typed ? typed_status : st);
  endtask

  // Drop valid and wait until every outstanding status has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // Write the capacity register while idle; the write empties the queue
  task automatic set_capacity(input logic [cfc_pkg::CAP_W-1:0] cap);
    wait_drained();
    repeat (2) @(negedge clk_i);
    cap_we_i    <= 1'b1;
    cap_wdata_i <= cap;
    @(negedge clk_i);
    cap_we_i    <= 1'b0;
    slots_used  = (cap == 0) ? 1 : ((cap > RING_DEPTH) ? RING_DEPTH : int'(cap));
    head_slot   = 0;
    tail_slot   = 0;
    ring_vacant = 1'b1;
  endtask

  task automatic check_field(input string tag, input logic [cfc_pkg::PORT_W-1:0] want,
                             input logic [cfc_pkg::PORT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per item, and the checker
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) stall_left = stall_left - 1;
  end

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = draw_gap();
      if (pending_status.size() == 0) begin
        $display("%0t: status item returned with no item outstanding", $time);
        errors++;
      end else begin
        want = pending_status.pop_front();
        check_field("accepted", flag_word(want.accepted), flag_word(out_accepted_o));
        check_field("oldest",   want.oldest,              out_oldest_value_o);
        check_field("newest",   want.newest,              out_newest_value_o);
        check_field("empty",    flag_word(want.empty),    flag_word(out_empty_flag_o));
        check_field("full",     flag_word(want.full),     flag_word(out_full_flag_o));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int cap;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: register rows drain first, item rows go straight in
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CAP) begin
        set_capacity(PLAN[i].value[cfc_pkg::CAP_W-1:0]);
      end else begin
        send_item(PLAN[i].func, PLAN[i].value, PLAN[i].typed, PLAN[i].status);
      end
    end

    // Random phases, each under a fresh capacity; some run with no gaps
    foreach (PHASE_CAPS[p]) begin
      cap = (PHASE_CAPS[p] == CAP_RANDOM) ? $urandom_range(0, 2047) : PHASE_CAPS[p];
      set_capacity(cap[cfc_pkg::CAP_W-1:0]);
      calm_phase = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        // Hold the sender mid-phase until the queue of results runs dry
        if (i == PHASE_ITEMS[p] / 2) wait_drained();
        send_item(draw_func(PHASE_ENQ_PCT[p]), draw_value(), 1'b0, ST_NONE);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
